FILE: hdl/mrs_pkg.sv
// mrs_pkg: constants, reply word table and shared types for the reply spotter
// used by mrs_matcher and module_reply_spotter_core, no dependencies
package mrs_pkg;

    localparam int unsigned ReplyCount = 10;
    localparam int unsigned MaxLen     = 17;
    localparam int unsigned PosWidth   = 5;
    localparam int unsigned CodeWidth  = 4;
    localparam int unsigned ByteWidth  = 8;
    localparam int unsigned MaskWidth  = 10;
    localparam int unsigned AddrWidth  = 3;
    localparam int unsigned DataWidth  = 32;

    // reply codes
    localparam logic [CodeWidth-1:0] CodeOk         = 4'd0;
    localparam logic [CodeWidth-1:0] CodeErr        = 4'd1;
    localparam logic [CodeWidth-1:0] CodeWpsSuccess = 4'd2;
    localparam logic [CodeWidth-1:0] CodeAssociated = 4'd3;
    localparam logic [CodeWidth-1:0] CodeOpen       = 4'd4;
    localparam logic [CodeWidth-1:0] CodeClose      = 4'd5;
    localparam logic [CodeWidth-1:0] CodeCmd        = 4'd6;
    localparam logic [CodeWidth-1:0] CodeExit       = 4'd7;
    localparam logic [CodeWidth-1:0] CodeSaved      = 4'd8;
    localparam logic [CodeWidth-1:0] CodeWpsFailed  = 4'd9;

    // register addresses
    localparam logic [AddrWidth-1:0] AddrFilterMask = 3'd0;

    typedef struct packed {
        logic                 complete;
        logic [CodeWidth-1:0] code;
        logic                 evt;
        logic                 link_open;
        logic                 joined;
    } result_t;

    function automatic logic [PosWidth-1:0] reply_len(input logic [CodeWidth-1:0] code);
        logic [PosWidth-1:0] len;
        case (code)
            CodeOk:         len = 5'd2;
            CodeErr:        len = 5'd3;
            CodeWpsSuccess: len = 5'd12;
            CodeAssociated: len = 5'd11;
            CodeOpen:       len = 5'd6;
            CodeClose:      len = 5'd6;
            CodeCmd:        len = 5'd3;
            CodeExit:       len = 5'd4;
            CodeSaved:      len = 5'd17;
            CodeWpsFailed:  len = 5'd10;
            default:        len = 5'd0;
        endcase
        return len;
    endfunction

    // character at a position of a reply word, only meaningful below its length
    function automatic logic [ByteWidth-1:0] reply_char(input logic [CodeWidth-1:0] code,
                                                        input logic [PosWidth-1:0] pos);
        logic [MaxLen*ByteWidth-1:0] text;
        logic [PosWidth-1:0]         len;
        logic [PosWidth-1:0]         sh;
        len = reply_len(code);
        case (code)
            CodeOk:         text = (MaxLen*ByteWidth)'("OK");
            CodeErr:        text = (MaxLen*ByteWidth)'("ERR");
            CodeWpsSuccess: text = (MaxLen*ByteWidth)'("WPS-SUCCESS!");
            CodeAssociated: text = (MaxLen*ByteWidth)'("Associated!");
            CodeOpen:       text = (MaxLen*ByteWidth)'("*OPEN*");
            CodeClose:      text = (MaxLen*ByteWidth)'("*CLOS*");
            CodeCmd:        text = (MaxLen*ByteWidth)'("CMD");
            CodeExit:       text = (MaxLen*ByteWidth)'("EXIT");
            CodeSaved:      text = (MaxLen*ByteWidth)'("Storing in config");
            CodeWpsFailed:  text = (MaxLen*ByteWidth)'("WPS-FAILED");
            default:        text = '0;
        endcase
        if (pos < len)
        begin
            sh = len - 5'd1 - pos;
        end
        else
        begin
            sh = '0;
        end
        return text[sh*ByteWidth +: ByteWidth];
    endfunction

endpackage

FILE: hdl/mrs_matcher.sv
// mrs_matcher: shared position counter, link flags and the parallel word compare
// depends on mrs_pkg
module mrs_matcher
(
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           step,
    input  logic [mrs_pkg::ByteWidth-1:0]  rx_char,
    input  logic [mrs_pkg::MaskWidth-1:0]  filter_mask,
    output mrs_pkg::result_t               result
);

    logic [mrs_pkg::PosWidth-1:0]   pos_reg;
    logic [mrs_pkg::PosWidth-1:0]   pos_next;
    logic                           open_reg;
    logic                           open_next;
    logic                           assoc_reg;
    logic                           assoc_next;

    logic [mrs_pkg::ReplyCount-1:0] hit;
    logic                           accepted;
    logic [mrs_pkg::CodeWidth-1:0]  sel;
    logic [mrs_pkg::PosWidth-1:0]   pos_inc;
    logic                           done;
    logic                           evt;

    // all ten words compared at once
    always_comb
    begin
        for (int k = 0; k < mrs_pkg::ReplyCount; k++)
        begin
            hit[k] = (pos_reg < mrs_pkg::reply_len(mrs_pkg::CodeWidth'(k))) &&
                     (rx_char == mrs_pkg::reply_char(mrs_pkg::CodeWidth'(k), pos_reg));
        end
    end

    // first word in table order wins
    always_comb
    begin
        sel = '0;
        for (int k = mrs_pkg::ReplyCount - 1; k >= 0; k--)
        begin
            if (hit[k])
            begin
                sel = mrs_pkg::CodeWidth'(k);
            end
        end
    end

    assign accepted = |hit;
    assign pos_inc  = pos_reg + 5'd1;
    assign done     = accepted && (pos_inc == mrs_pkg::reply_len(sel));

    always_comb
    begin
        open_next  = open_reg;
        assoc_next = assoc_reg;
        evt        = 1'b0;
        if (done)
        begin
            case (sel)
                mrs_pkg::CodeOpen:
                begin
                    open_next = 1'b1;
                    evt       = 1'b1;
                end
                mrs_pkg::CodeClose:
                begin
                    open_next = 1'b0;
                    evt       = 1'b1;
                end
                mrs_pkg::CodeAssociated:
                begin
                    assoc_next = 1'b1;
                    evt        = 1'b1;
                end
                default:
                begin
                    evt = filter_mask[sel];
                end
            endcase
        end
        if (accepted && !done)
        begin
            pos_next = pos_inc;
        end
        else
        begin
            pos_next = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg   <= '0;
            open_reg  <= 1'b0;
            assoc_reg <= 1'b0;
        end
        else if (step)
        begin
            pos_reg   <= pos_next;
            open_reg  <= open_next;
            assoc_reg <= assoc_next;
        end
    end

    always_comb
    begin
        result.complete  = done;
        result.code      = done ? sel : mrs_pkg::CodeOk;
        result.evt       = evt;
        result.link_open = open_next;
        result.joined    = assoc_next;
    end

endmodule

FILE: hdl/module_reply_spotter_core.sv
// module_reply_spotter_core: top level with byte register, result register and APB port
// depends on mrs_pkg and mrs_matcher
//
// Takes one received byte per word on the rx channel and gives one result word per byte
// on the reply channel. A byte is registered, matched against the ten reply words
// combinationally and the result is registered, so a new byte is taken every cycle while
// the reply channel does not stall; a result is offered once its byte has passed the byte
// register and the result register. The shared position counter and the open and associated
// flags advance as each byte moves into the result register. The filter mask lives at APB
// address 0; the user must write it only while idle, the block does not enforce this.
module module_reply_spotter_core
(
    input  logic                           clk,
    input  logic                           rst_n,

    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [mrs_pkg::AddrWidth-1:0]  paddr,
    input  logic [mrs_pkg::DataWidth-1:0]  pwdata,
    output logic [mrs_pkg::DataWidth-1:0]  prdata,
    output logic                           pready,

    input  logic                           rx_valid,
    output logic                           rx_stall,
    input  logic [mrs_pkg::ByteWidth-1:0]  rx_byte,

    output logic                           reply_valid,
    input  logic                           reply_stall,
    output logic                           reply_complete,
    output logic [mrs_pkg::CodeWidth-1:0]  reply_code,
    output logic                           event_raised,
    output logic                           link_open,
    output logic                           joined_network
);

    logic [mrs_pkg::MaskWidth-1:0]  mask_reg;
    logic                           byte_valid_reg;
    logic                           byte_valid_next;
    logic [mrs_pkg::ByteWidth-1:0]  byte_reg;
    logic                           reply_valid_reg;
    logic                           reply_valid_next;
    mrs_pkg::result_t               result_reg;
    mrs_pkg::result_t               result_next;
    logic                           advance;
    logic                           mask_sel;

    // config port
    assign pready   = 1'b1;
    assign mask_sel = (paddr[mrs_pkg::AddrWidth-1:2]
                       == mrs_pkg::AddrFilterMask[mrs_pkg::AddrWidth-1:2]);
    assign prdata   = mask_sel ? mrs_pkg::DataWidth'(mask_reg) : '0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mask_reg <= '0;
        end
        else if (psel && penable && pwrite && pready && mask_sel)
        begin
            mask_reg <= pwdata[mrs_pkg::MaskWidth-1:0];
        end
    end

    // byte register and result register handshake
    assign advance  = byte_valid_reg && (!reply_valid_reg || !reply_stall);
    assign rx_stall = byte_valid_reg && reply_valid_reg && reply_stall;

    always_comb
    begin
        byte_valid_next = rx_stall ? byte_valid_reg : rx_valid;
        if (advance)
        begin
            reply_valid_next = 1'b1;
        end
        else if (reply_stall)
        begin
            reply_valid_next = reply_valid_reg;
        end
        else
        begin
            reply_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            byte_valid_reg  <= 1'b0;
            reply_valid_reg <= 1'b0;
        end
        else
        begin
            byte_valid_reg  <= byte_valid_next;
            reply_valid_reg <= reply_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rx_valid && !rx_stall)
        begin
            byte_reg <= rx_byte;
        end
        if (advance)
        begin
            result_reg <= result_next;
        end
    end

    mrs_matcher u_matcher
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .step        (advance),
        .rx_char     (byte_reg),
        .filter_mask (mask_reg),
        .result      (result_next)
    );

    assign reply_valid    = reply_valid_reg;
    assign reply_complete = result_reg.complete;
    assign reply_code     = result_reg.code;
    assign event_raised   = result_reg.evt;
    assign link_open      = result_reg.link_open;
    assign joined_network = result_reg.joined;

endmodule
